@@ sv/rofi_pkg.sv @@
package rofi_pkg;

  localparam int unsigned LEVEL_W    = 4;
  localparam int unsigned PRICE_W    = 32;
  localparam int unsigned VOL_W      = 24;
  localparam int unsigned MAX_LEVELS = 10;
  localparam int unsigned RAW_W      = 30;
  localparam int unsigned SUM_W      = 38;
  localparam int unsigned ABS_W      = 37;
  localparam int unsigned WIN_MAX    = 256;
  localparam int unsigned HEAD_W     = 8;
  localparam int unsigned FILL_W     = 9;
  localparam int unsigned WLEN_W     = 9;
  localparam int unsigned LU_W       = 4;
  localparam int unsigned NORM_W     = 16;
  localparam int unsigned Q_W        = 16;
  localparam int unsigned DCNT_W     = 4;
  localparam int unsigned DIV_STEPS  = 16;

  localparam int unsigned IN_FIELDS_W = LEVEL_W + 2 * PRICE_W + 2 * VOL_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = NORM_W + RAW_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int unsigned LV_LSB = 0;
  localparam int unsigned BP_LSB = LV_LSB + LEVEL_W;
  localparam int unsigned BV_LSB = BP_LSB + PRICE_W;
  localparam int unsigned AP_LSB = BV_LSB + VOL_W;
  localparam int unsigned AV_LSB = AP_LSB + PRICE_W;

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(16);
  localparam logic [LU_W-1:0]   LU_RESET   = LU_W'(5);

  typedef enum logic [0:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_LEVELS_IN_USE = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_START,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic accept;
    logic push;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } status_t;

endpackage

@@ sv/rolling_order_flow_imbalance_core.sv @@
// Rolling multi-level order flow imbalance.
// Level words are taken one per cycle while the core is idle; the last level of a
// snapshot starts a ring push and a 16-step restoring divider, and input is held
// off until the result word is loaded into the output register once it is free.
// Reset (rst_ni low, asynchronous) clears the prior book, the rolling sums, the ring
// pointers and the output valid flag; window_length returns to 16, levels_in_use to 5.
module rolling_order_flow_imbalance_core import rofi_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // level_index, bid_price, bid_volume, ask_price, ask_volume
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // normalized_ofi, snapshot_ofi
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [WLEN_W-1:0] wlen_q;
  logic [LU_W-1:0]   lu_q;
  reg_idx_e          reg_idx;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WLEN_RESET;
      lu_q   <= LU_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_WINDOW_LENGTH: wlen_q <= pwdata[WLEN_W-1:0];
        REG_LEVELS_IN_USE: lu_q   <= pwdata[LU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW_LENGTH: prdata = {{(32-WLEN_W){1'b0}}, wlen_q};
      REG_LEVELS_IN_USE: prdata = {{(32-LU_W){1'b0}}, lu_q};
      default:           prdata = '0;
    endcase
  end

  cmd_t    cmd;
  status_t status;

  rofi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rofi_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .in_data_i       (s_axis_tdata),
    .in_last_i       (s_axis_tlast),
    .window_length_i (wlen_q),
    .levels_in_use_i (lu_q),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_data_o      (m_axis_tdata)
  );

endmodule

@@ sv/rofi_ctrl.sv @@
module rofi_ctrl import rofi_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_last_i) state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = ST_START;
      end
      ST_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ sv/rofi_dp.sv @@
module rofi_dp import rofi_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output status_t                status_o,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  input  logic                   in_last_i,
  input  logic [WLEN_W-1:0]      window_length_i,
  input  logic [LU_W-1:0]        levels_in_use_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  // level item fields
  logic [LEVEL_W-1:0] lv;
  logic [PRICE_W-1:0] bp, ap;
  logic [VOL_W-1:0]   bv, av;

  assign lv = in_data_i[LV_LSB +: LEVEL_W];
  assign bp = in_data_i[BP_LSB +: PRICE_W];
  assign bv = in_data_i[BV_LSB +: VOL_W];
  assign ap = in_data_i[AP_LSB +: PRICE_W];
  assign av = in_data_i[AV_LSB +: VOL_W];

  // previous snapshot
  logic [PRICE_W-1:0] prior_bp_q [MAX_LEVELS];
  logic [VOL_W-1:0]   prior_bv_q [MAX_LEVELS];
  logic [PRICE_W-1:0] prior_ap_q [MAX_LEVELS];
  logic [VOL_W-1:0]   prior_av_q [MAX_LEVELS];
  logic [LEVEL_W-1:0] prior_cnt_q;
  logic               have_prior_q;
  logic signed [RAW_W-1:0] acc_q;
  logic signed [RAW_W-1:0] raw_q;

  logic                lv_ok, term_en;
  logic [LEVEL_W-1:0]  idx;
  logic [PRICE_W-1:0]  pbp, pap;
  logic [VOL_W-1:0]    pbv, pav;
  logic signed [RAW_W-1:0] bvs, avs, pbvs, pavs, term, acc_sum;
  logic [LEVEL_W:0]    lv_p1;
  logic [LEVEL_W-1:0]  snap_cnt;

  assign lv_ok = lv < LEVEL_W'(MAX_LEVELS);
  assign idx   = lv_ok ? lv : '0;
  assign pbp   = prior_bp_q[idx];
  assign pbv   = prior_bv_q[idx];
  assign pap   = prior_ap_q[idx];
  assign pav   = prior_av_q[idx];

  assign bvs  = signed'({{(RAW_W-VOL_W){1'b0}}, bv});
  assign avs  = signed'({{(RAW_W-VOL_W){1'b0}}, av});
  assign pbvs = signed'({{(RAW_W-VOL_W){1'b0}}, pbv});
  assign pavs = signed'({{(RAW_W-VOL_W){1'b0}}, pav});

  always_comb begin
    term = (bp >= pbp) ? bvs : -bvs;
    if (bp <= pbp) term = term - pbvs;
    term = (ap <= pap) ? (term - avs) : (term + avs);
    if (ap >= pap) term = term + pavs;
  end

  assign term_en = have_prior_q && lv_ok && (lv < levels_in_use_i) && (lv < prior_cnt_q);
  assign acc_sum = term_en ? (acc_q + term) : acc_q;

  assign lv_p1    = {1'b0, lv} + (LEVEL_W+1)'(1);
  assign snap_cnt = (lv_p1 > (LEVEL_W+1)'(MAX_LEVELS)) ? LEVEL_W'(MAX_LEVELS)
                                                      : lv_p1[LEVEL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        prior_bp_q[i] <= '0;
        prior_bv_q[i] <= '0;
        prior_ap_q[i] <= '0;
        prior_av_q[i] <= '0;
      end
      prior_cnt_q  <= '0;
      have_prior_q <= 1'b0;
      acc_q        <= '0;
    end else if (cmd_i.accept) begin
      if (lv_ok) begin
        prior_bp_q[idx] <= bp;
        prior_bv_q[idx] <= bv;
        prior_ap_q[idx] <= ap;
        prior_av_q[idx] <= av;
      end
      if (in_last_i) begin
        prior_cnt_q  <= snap_cnt;
        have_prior_q <= 1'b1;
        acc_q        <= '0;
      end else begin
        acc_q <= acc_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_last_i) raw_q <= have_prior_q ? acc_sum : '0;
  end

  // history ring and rolling sums
  logic [RAW_W-1:0]  ring_mem [WIN_MAX];
  logic [RAW_W-1:0]  rd_q;
  logic [HEAD_W-1:0] head_q, oldest;
  logic [FILL_W-1:0] fill_q, eff_len;
  logic signed [SUM_W-1:0] sum_q;
  logic [ABS_W-1:0]  abs_q;
  logic              evict;
  logic signed [RAW_W-1:0] old_val;
  logic [RAW_W-1:0]  raw_mag, old_mag;

  assign oldest  = head_q - fill_q[HEAD_W-1:0];
  assign eff_len = (window_length_i == '0) ? FILL_W'(1) :
                   (window_length_i > WLEN_W'(WIN_MAX)) ? FILL_W'(WIN_MAX) : window_length_i;
  assign evict   = fill_q >= eff_len;
  assign old_val = evict ? signed'(rd_q) : '0;
  assign raw_mag = raw_q[RAW_W-1] ? unsigned'(-raw_q) : unsigned'(raw_q);
  assign old_mag = old_val[RAW_W-1] ? unsigned'(-old_val) : unsigned'(old_val);

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) ring_mem[head_q] <= raw_q;
    rd_q <= ring_mem[oldest];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
      abs_q  <= '0;
    end else if (cmd_i.push) begin
      head_q <= head_q + HEAD_W'(1);
      if (!evict) fill_q <= fill_q + FILL_W'(1);
      sum_q  <= sum_q + SUM_W'(raw_q) - SUM_W'(old_val);
      abs_q  <= abs_q + ABS_W'(raw_mag) - ABS_W'(old_mag);
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [ABS_W-1:0]  rem_q, den_q, sum_mag;
  logic [Q_W-1:0]    quo_q, mag;
  logic              neg_q, zero_q, first_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [ABS_W:0]    trial;
  logic [ABS_W:0]    trial_sub;
  logic              ge;
  logic signed [SUM_W-1:0] sum_neg;

  assign sum_neg   = -sum_q;
  assign sum_mag   = sum_q[SUM_W-1] ? sum_neg[ABS_W-1:0] : sum_q[ABS_W-1:0];
  assign trial     = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign ge        = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q  <= '0;
      first_q <= 1'b0;
    end else if (cmd_i.div_start) begin
      dcnt_q  <= '0;
      first_q <= 1'b1;
    end else if (cmd_i.div_step) begin
      dcnt_q  <= dcnt_q + DCNT_W'(1);
      first_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q  <= sum_mag;
      den_q  <= abs_q;
      neg_q  <= sum_q[SUM_W-1];
      zero_q <= (abs_q == '0);
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? trial_sub[ABS_W-1:0] : trial[ABS_W-1:0];
      quo_q <= {quo_q[Q_W-2:0], ge};
    end
  end

  assign status_o.div_last = dcnt_q == DCNT_W'(DIV_STEPS - 1);

  // output word register
  logic              out_valid_q;
  logic [NORM_W-1:0] norm_q, norm_d;
  logic [RAW_W-1:0]  out_raw_q;

  assign mag = (quo_q > Q_W'(32768)) ? Q_W'(32768) : quo_q;

  always_comb begin
    if (zero_q)                  norm_d = '0;
    else if (neg_q)              norm_d = -mag;
    else if (mag == Q_W'(32768)) norm_d = NORM_W'(32767);
    else                         norm_d = mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      norm_q    <= norm_d;
      out_raw_q <= raw_q;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, out_raw_q, norm_q};

endmodule
